/* rtl/core/nssai_pkg.sv */
// Package for the NSSAI information element decoder.
// Request payload types and entry-length codes; no dependencies.
`timescale 1ns / 1ps

package nssai_pkg;

    // Supported S-NSSAI entry length codes
    localparam logic [7:0] LEN_SST        = 8'd1;
    localparam logic [7:0] LEN_SST_SD     = 8'd4;
    localparam logic [7:0] LEN_SST_SD_MST = 8'd5;
    localparam logic [7:0] LEN_FULL       = 8'd8;

    // SD value reported when the SD is absent but its slice type is present
    localparam logic [23:0] NO_SD = 24'hFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_element;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  slice_type;
        logic [23:0] slice_diff;
        logic [7:0]  mapped_type;
        logic [23:0] mapped_diff;
        logic [3:0]  entry_length;
        logic        last_entry;
        logic        bad_length;
    } t_out_req;

endpackage

/* rtl/core/nssai_ie_decoder_unit.sv */
// NSSAI information element decoder, top level.
// Depends on nssai_pkg for the request types and length codes.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_stall, i_in_data) carries one byte of the
//   element per request; start_of_element marks the first byte of an element.
//   Output channel (o_out_valid / i_out_stall, o_out_data) carries one request
//   per decoded S-NSSAI entry, or one with bad_length set when an entry length
//   byte is not 1, 4, 5 or 8 (the rest of that element is then dropped).
//   Config channel (i_cfg_valid / o_cfg_ready, i_cfg_iei_present) writes the
//   identifier-present flag; write it only while the decoder is idle.
// Timing:
//   One byte is accepted per cycle while o_in_stall is low. The parser state updates in the cycle the
//   byte is accepted; a result is registered into the output register, or into the skid entry
//   when the output register holds a result that is not taken.
//   The output register is backed by one skid entry, so a byte may be taken
//   while a result waits. o_in_stall rises only when both hold a result, and
//   drops the cycle after the receiver takes one.
// Reset:
//   Synchronous active-low reset empties both output stages, sets the parser to
//   wait for an element start and clears the identifier-present flag.
module nssai_ie_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  nssai_pkg::t_in_req i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output nssai_pkg::t_out_req o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_iei_present
);
    import nssai_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TOTAL,
        PH_ENTLEN,
        PH_BODY
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_iei_present;
    logic [7:0]  r_rem_total, n_rem_total;
    logic [3:0]  r_entry_len, n_entry_len;
    logic [3:0]  r_byte_pos, n_byte_pos;
    logic [7:0]  r_acc_type, n_acc_type;
    logic [23:0] r_acc_diff, n_acc_diff;
    logic [7:0]  r_acc_mtype, n_acc_mtype;
    logic [23:0] r_acc_mdiff, n_acc_mdiff;

    logic        r_out_valid;
    t_out_req    r_out_data;
    logic        r_skid_valid;
    t_out_req    r_skid_data;

    logic        in_fire;
    logic        out_fire;
    logic        res_valid;
    t_out_req    res;
    t_phase      cur_phase;
    logic [7:0]  rem_dec;
    logic [7:0]  b;

    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_fire    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    assign b       = i_in_data.data_byte;
    assign rem_dec = (r_rem_total != 8'd0) ? r_rem_total - 8'd1 : 8'd0;

    always_comb begin
        n_phase     = r_phase;
        n_rem_total = r_rem_total;
        n_entry_len = r_entry_len;
        n_byte_pos  = r_byte_pos;
        n_acc_type  = r_acc_type;
        n_acc_diff  = r_acc_diff;
        n_acc_mtype = r_acc_mtype;
        n_acc_mdiff = r_acc_mdiff;
        res_valid   = 1'b0;
        res         = '0;
        cur_phase   = r_phase;

        if (in_fire) begin
            if (i_in_data.start_of_element) begin
                n_byte_pos  = '0;
                n_acc_type  = '0;
                n_acc_diff  = '0;
                n_acc_mtype = '0;
                n_acc_mdiff = '0;
                n_entry_len = '0;
                n_rem_total = '0;
                n_phase     = PH_TOTAL;
                // identifier byte is swallowed; otherwise this byte is the total
                cur_phase   = r_iei_present ? PH_IDLE : PH_TOTAL;
            end

            unique case (cur_phase)
                PH_IDLE: begin
                end
                PH_TOTAL: begin
                    n_rem_total = b;
                    n_phase     = (b != 8'd0) ? PH_ENTLEN : PH_IDLE;
                end
                PH_ENTLEN: begin
                    n_rem_total = rem_dec;
                    if (b == LEN_SST || b == LEN_SST_SD || b == LEN_SST_SD_MST ||
                        b == LEN_FULL) begin
                        n_entry_len = b[3:0];
                        n_byte_pos  = '0;
                        n_acc_type  = '0;
                        n_acc_diff  = '0;
                        n_acc_mtype = '0;
                        n_acc_mdiff = '0;
                        n_phase     = PH_BODY;
                    end else begin
                        res_valid        = 1'b1;
                        res.entry_length = b[3:0];
                        res.last_entry   = 1'b1;
                        res.bad_length   = 1'b1;
                        n_phase          = PH_IDLE;
                    end
                end
                PH_BODY: begin
                    n_rem_total = rem_dec;
                    n_byte_pos  = r_byte_pos + 4'd1;
                    if (n_byte_pos == 4'd1) begin
                        n_acc_type = b;
                    end else if (n_byte_pos <= 4'd4) begin
                        n_acc_diff = {r_acc_diff[15:0], b};
                    end else if (n_byte_pos == 4'd5) begin
                        n_acc_mtype = b;
                    end else begin
                        n_acc_mdiff = {r_acc_mdiff[15:0], b};
                    end

                    if (n_byte_pos == r_entry_len) begin
                        res_valid        = 1'b1;
                        res.slice_type   = n_acc_type;
                        res.entry_length = r_entry_len;
                        res.last_entry   = (rem_dec == 8'd0);
                        res.bad_length   = 1'b0;
                        priority if ({4'd0, r_entry_len} == LEN_SST) begin
                            res.slice_diff  = NO_SD;
                            res.mapped_type = '0;
                            res.mapped_diff = '0;
                        end else if ({4'd0, r_entry_len} == LEN_SST_SD) begin
                            res.slice_diff  = n_acc_diff;
                            res.mapped_type = '0;
                            res.mapped_diff = '0;
                        end else if ({4'd0, r_entry_len} == LEN_SST_SD_MST) begin
                            res.slice_diff  = n_acc_diff;
                            res.mapped_type = n_acc_mtype;
                            res.mapped_diff = NO_SD;
                        end else begin
                            res.slice_diff  = n_acc_diff;
                            res.mapped_type = n_acc_mtype;
                            res.mapped_diff = n_acc_mdiff;
                        end
                        n_byte_pos  = '0;
                        n_acc_type  = '0;
                        n_acc_diff  = '0;
                        n_acc_mtype = '0;
                        n_acc_mdiff = '0;
                        n_phase     = (rem_dec != 8'd0) ? PH_ENTLEN : PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_iei_present <= 1'b0;
            r_rem_total   <= '0;
            r_entry_len   <= '0;
            r_byte_pos    <= '0;
            r_acc_type    <= '0;
            r_acc_diff    <= '0;
            r_acc_mtype   <= '0;
            r_acc_mdiff   <= '0;
        end else begin
            r_phase     <= n_phase;
            r_rem_total <= n_rem_total;
            r_entry_len <= n_entry_len;
            r_byte_pos  <= n_byte_pos;
            r_acc_type  <= n_acc_type;
            r_acc_diff  <= n_acc_diff;
            r_acc_mtype <= n_acc_mtype;
            r_acc_mdiff <= n_acc_mdiff;
            if (i_cfg_valid && o_cfg_ready) begin
                r_iei_present <= i_cfg_iei_present;
            end
        end
    end

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_data  <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output stages not empty after reset");

    a_bad_len_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bad_length) |->
            (o_out_data.last_entry && o_out_data.slice_type == 8'd0 &&
             o_out_data.slice_diff == 24'd0 && o_out_data.mapped_type == 8'd0 &&
             o_out_data.mapped_diff == 24'd0))
        else $error("bad length result not terminal or not zeroed");

    a_stall_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !out_fire) |=> r_skid_valid)
        else $error("skid entry lost while output stalled");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for nssai_ie_decoder_unit: directed table, then random elements.
// Depends on nssai_pkg and the decoder RTL; carries its own byte-level decode predictor.
`timescale 1ns / 1ps

module tb_top;
    import nssai_pkg::*;

    typedef enum logic [1:0] {P_IDLE, P_TOTAL, P_ENTLEN, P_BODY} t_parse_phase;

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_req want;
    } t_dir_row;

    logic     i_clk    = 1'b0;
    logic     i_rst_n  = 1'b0;
    logic     in_valid = 1'b0;
    t_in_req  in_data  = '0;
    logic     out_stall = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_iei   = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_data;
    logic     o_cfg_ready;

    // predictor state
    bit           iei_cfg;
    t_parse_phase ph;
    logic [7:0]   rem_total;
    logic [7:0]   ent_len;
    logic [3:0]   pos;
    logic [7:0]   acc_sst;
    logic [23:0]  acc_sd;
    logic [7:0]   acc_msst;
    logic [23:0]  acc_msd;

    t_out_req pending_entries[$];
    t_dir_row dir_tab[$];
    int       fails = 0;
    int       in_idle_pct = 0;
    int       out_stall_pct = 0;
    int       hold_left = 0;

    nssai_ie_decoder_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_data         (in_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_out_data        (o_out_data),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_iei_present (cfg_iei)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit len_ok(logic [7:0] b);
        return b == LEN_SST || b == LEN_SST_SD || b == LEN_SST_SD_MST || b == LEN_FULL;
    endfunction

    function void clear_acc();
        acc_sst  = '0;
        acc_sd   = '0;
        acc_msst = '0;
        acc_msd  = '0;
        pos      = '0;
    endfunction

    function void reset_decoder();
        iei_cfg   = 1'b0;
        ph        = P_IDLE;
        rem_total = '0;
        ent_len   = '0;
        clear_acc();
    endfunction

    // Advances the predicted parser by one byte; returns 1 when an entry result is due.
    // live is 0 for a byte the parser ignores.
    function bit decode_byte(input t_in_req r, output t_out_req res, output bit live);
        logic [7:0] b;
        b    = r.data_byte;
        res  = '0;
        live = r.start_of_element || ph != P_IDLE;
        if (r.start_of_element) begin
            clear_acc();
            ent_len   = '0;
            rem_total = '0;
            ph        = P_TOTAL;
            if (iei_cfg) return 1'b0;
        end
        case (ph)
            P_TOTAL: begin
                rem_total = b;
                ph = (b != 0) ? P_ENTLEN : P_IDLE;
                return 1'b0;
            end
            P_ENTLEN: begin
                if (rem_total != 0) rem_total--;
                if (len_ok(b)) begin
                    ent_len = b;
                    clear_acc();
                    ph = P_BODY;
                    return 1'b0;
                end
                res.entry_length = b[3:0];
                res.last_entry   = 1'b1;
                res.bad_length   = 1'b1;
                ph = P_IDLE;
                return 1'b1;
            end
            P_BODY: begin
                if (rem_total != 0) rem_total--;
                pos = pos + 4'd1;
                if (pos == 1)      acc_sst  = b;
                else if (pos <= 4) acc_sd   = {acc_sd[15:0], b};
                else if (pos == 5) acc_msst = b;
                else               acc_msd  = {acc_msd[15:0], b};
                if ({4'd0, pos} != ent_len) return 1'b0;
                res.slice_type  = acc_sst;
                res.slice_diff  = (ent_len == LEN_SST) ? NO_SD : acc_sd;
                res.mapped_type = (ent_len == LEN_SST || ent_len == LEN_SST_SD) ? 8'h00
                                                                                 : acc_msst;
                if (ent_len == LEN_FULL)            res.mapped_diff = acc_msd;
                else if (ent_len == LEN_SST_SD_MST) res.mapped_diff = NO_SD;
                else                                res.mapped_diff = '0;
                res.entry_length = ent_len[3:0];
                res.last_entry   = (rem_total == 0);
                res.bad_length   = 1'b0;
                clear_acc();
                ph = (rem_total != 0) ? P_ENTLEN : P_IDLE;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_dir_row ent(logic [7:0] b, logic sop);
        t_dir_row d;
        d.req   = '{data_byte: b, start_of_element: sop};
        d.typed = 1'b0;
        d.want  = '0;
        return d;
    endfunction

    function automatic t_dir_row chk(logic [7:0] b, logic sop, t_out_req w);
        t_dir_row d;
        d = ent(b, sop);
        d.typed = 1'b1;
        d.want  = w;
        return d;
    endfunction

    function automatic logic [7:0] rnd_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one byte, with random idle cycles ahead of it, and predict once it is taken.
    task automatic push_byte(input t_in_req r, input bit typed, input t_out_req want,
                             output bit live);
        t_out_req res;
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        if (decode_byte(r, res, live))
            pending_entries.push_back(typed ? want : res);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_iei(bit v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_iei   <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        iei_cfg = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // One element: mostly well formed, sometimes short/overlong total, bad length,
    // truncated by the next start, empty, or preceded by stray bytes.
    task automatic send_element(inout int live_cnt);
        t_in_req    bytes[$];
        int         starts[$];
        int         n_ent;
        int         kind;
        int         cut;
        logic [7:0] code;
        logic [7:0] total;
        bit         live;
        n_ent = $urandom_range(1, 4);
        for (int e = 0; e < n_ent; e++) begin
            case ($urandom_range(3))
                0:       code = LEN_SST;
                1:       code = LEN_SST_SD;
                2:       code = LEN_SST_SD_MST;
                default: code = LEN_FULL;
            endcase
            starts.push_back(bytes.size());
            bytes.push_back('{data_byte: code, start_of_element: 1'b0});
            for (int k = 0; k < code; k++)
                bytes.push_back('{data_byte: rnd_byte(), start_of_element: 1'b0});
        end
        total = 8'(bytes.size());
        kind  = $urandom_range(99);
        if (kind >= 80 && kind < 85) begin
            total = 8'($urandom_range(0, bytes.size() - 1));
        end else if (kind >= 85 && kind < 89) begin
            do code = 8'($urandom); while (len_ok(code));
            bytes[starts[$urandom_range(0, starts.size() - 1)]].data_byte = code;
        end else if (kind >= 89 && kind < 93) begin
            cut = $urandom_range(1, bytes.size() - 1);
            while (bytes.size() > cut) bytes.delete(bytes.size() - 1);
        end else if (kind >= 93 && kind < 96) begin
            bytes.delete();
            total = 8'h00;
        end else if (kind >= 96) begin
            repeat ($urandom_range(1, 3)) begin
                push_byte('{data_byte: 8'($urandom), start_of_element: 1'b0}, 1'b0, '0, live);
                if (live) live_cnt++;
            end
        end
        bytes.push_front('{data_byte: total, start_of_element: !iei_cfg});
        if (iei_cfg)
            bytes.push_front('{data_byte: 8'($urandom), start_of_element: 1'b1});
        foreach (bytes[i]) begin
            push_byte(bytes[i], 1'b0, '0, live);
            if (live) live_cnt++;
        end
    endtask

    task automatic run_phase(bit iei, int in_pct, int out_pct, int n_items, int hold);
        int live_cnt;
        live_cnt = 0;
        drain();
        write_iei(iei);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        hold_left     = hold;
        while (live_cnt < n_items) send_element(live_cnt);
    endtask

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin : entry_check
        t_out_req want;
        t_out_req got;
        if (i_rst_n && o_out_valid && !out_stall) begin
            got = o_out_data;
            if (pending_entries.size() == 0) begin
                $error("unexpected result: %h", got);
                fails++;
            end else begin
                want = pending_entries.pop_front();
                if (got.slice_type !== want.slice_type) begin
                    $error("slice_type: expected %0h, got %0h", want.slice_type, got.slice_type);
                    fails++;
                end
                if (got.slice_diff !== want.slice_diff) begin
                    $error("slice_diff: expected %0h, got %0h", want.slice_diff, got.slice_diff);
                    fails++;
                end
                if (got.mapped_type !== want.mapped_type) begin
                    $error("mapped_type: expected %0h, got %0h", want.mapped_type,
                           got.mapped_type);
                    fails++;
                end
                if (got.mapped_diff !== want.mapped_diff) begin
                    $error("mapped_diff: expected %0h, got %0h", want.mapped_diff,
                           got.mapped_diff);
                    fails++;
                end
                if (got.entry_length !== want.entry_length) begin
                    $error("entry_length: expected %0h, got %0h", want.entry_length,
                           got.entry_length);
                    fails++;
                end
                if (got.last_entry !== want.last_entry) begin
                    $error("last_entry: expected %0h, got %0h", want.last_entry, got.last_entry);
                    fails++;
                end
                if (got.bad_length !== want.bad_length) begin
                    $error("bad_length: expected %0h, got %0h", want.bad_length, got.bad_length);
                    fails++;
                end
            end
        end
    end

    initial begin
        bit live;
        reset_decoder();
        dir_tab = {
            ent(8'hA5, 1'b0),                       // outside an element, ignored
            ent(8'h0B, 1'b1),                       // total 11
            ent(LEN_SST, 1'b0),
            chk(8'hFF, 1'b0, {8'hFF, NO_SD, 8'h00, 24'h0, 4'd1, 1'b0, 1'b0}),
            ent(LEN_FULL, 1'b0),
            ent(8'hFF, 1'b0), ent(8'hFF, 1'b0), ent(8'hFF, 1'b0), ent(8'hFF, 1'b0),
            ent(8'hFF, 1'b0), ent(8'hFF, 1'b0), ent(8'hFF, 1'b0),
            chk(8'hFF, 1'b0, {8'hFF, 24'hFFFFFF, 8'hFF, 24'hFFFFFF, 4'd8, 1'b1, 1'b0}),
            ent(8'h00, 1'b1),                       // empty element
            ent(8'hFF, 1'b1),
            chk(8'hFF, 1'b0, {8'h00, 24'h0, 8'h00, 24'h0, 4'hF, 1'b1, 1'b1}),
            ent(LEN_SST, 1'b0),                     // dropped after bad length
            ent(8'h03, 1'b1),
            ent(LEN_SST_SD, 1'b0),
            ent(8'h00, 1'b0),                       // cut short by the next start
            ent(8'h01, 1'b1),                       // total shorter than the entry
            ent(LEN_SST_SD_MST, 1'b0),
            ent(8'h00, 1'b0), ent(8'h00, 1'b0), ent(8'h00, 1'b0), ent(8'h01, 1'b0),
            chk(8'h80, 1'b0, {8'h00, 24'h000001, 8'h80, NO_SD, 4'd5, 1'b1, 1'b0})
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            push_byte(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want, live);

        run_phase(1'b1, 0,  0,  160, 0);
        run_phase(1'b0, 87, 0,  160, 0);
        run_phase(1'b1, 0,  87, 160, 0);
        run_phase(1'b0, 18, 18, 160, 0);
        run_phase(1'b1, 0,  0,  160, 400);   // long receiver hold-off fills the block

        @(negedge i_clk);
        in_valid <= 1'b0;
        for (int n = 0; n < 20000 && pending_entries.size() != 0; n++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_entries.size() != 0) begin
            $error("%0d results never arrived", pending_entries.size());
            fails++;
        end
        if (fails == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/nssai_pkg.sv
rtl/core/nssai_ie_decoder_unit.sv
dv/tb_top.sv
